FILE: src/lighting_energy_comfort_metrics_assert.svh
// Assertion macros for the lighting metrics block.
// Used by the controller, datapath and divider; expects i_clk and i_rst_n in scope.
`ifndef LIGHTING_ENERGY_COMFORT_METRICS_ASSERT_SVH
`define LIGHTING_ENERGY_COMFORT_METRICS_ASSERT_SVH

`ifndef ASSERT_OFF
`define LECM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LECM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LECM_ASSERT_IMPL(lbl, ante, cons, msg)
`define LECM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/lecm_pkg.sv
// Shared constants and types for the lighting metrics block.
// No dependencies.
`timescale 1ns / 1ps

package lecm_pkg;

    localparam int NODE_COUNT     = 8;
    localparam int NODE_W         = 3;
    localparam int NODE_IDX_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int TS_W           = 48;
    localparam int PWM_W          = 8;
    localparam int ILLUM_W        = 16;
    localparam int ENERGY_W       = 64;
    localparam int SUM_W          = 48;
    localparam int PROD_W         = PWM_W + TS_W;
    localparam int ABS_W          = ILLUM_W + 1;
    localparam int SCALE_W        = 19;
    localparam int NUM_W          = ABS_W + SCALE_W;
    localparam int CNT_W          = 2;
    localparam int HISTORY_NEEDED = 3;

    localparam logic [SCALE_W-1:0] FLICKER_SCALE = SCALE_W'(500000);
    localparam logic [0:0]         OP_DUTY       = 1'b0;
    localparam logic [0:0]         OP_ILLUM      = 1'b1;

    typedef struct packed {
        logic               op;
        logic [NODE_W-1:0]  node;
        logic [PWM_W-1:0]   pwm_value;
        logic [ILLUM_W-1:0] illuminance;
        logic [ILLUM_W-1:0] reference;
        logic [TS_W-1:0]    timestamp_us;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]   out_node;
        logic [ENERGY_W-1:0] energy_sum;
        logic [SUM_W-1:0]    comfort_error_sum;
        logic [SUM_W-1:0]    flicker_sum;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic calc;
        logic mul;
        logic div_start;
        logic wb;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_busy;
    } t_dp_status;

endpackage

FILE: src/lecm_in_if.sv
// Sample input channel: valid/ready plus the sample fields.
// Depends on lecm_pkg.
`timescale 1ns / 1ps

interface lecm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [lecm_pkg::NODE_W-1:0]  node;
    logic [lecm_pkg::PWM_W-1:0]   pwm_value;
    logic [lecm_pkg::ILLUM_W-1:0] illuminance;
    logic [lecm_pkg::ILLUM_W-1:0] reference;
    logic [lecm_pkg::TS_W-1:0]    timestamp_us;

    modport source (output valid, op, node, pwm_value, illuminance, reference, timestamp_us,
                    input ready);
    modport sink (input valid, op, node, pwm_value, illuminance, reference, timestamp_us,
                  output ready);
endinterface

FILE: src/lecm_out_if.sv
// Result channel: valid/ready plus the reported sums.
// Depends on lecm_pkg.
`timescale 1ns / 1ps

interface lecm_out_if;
    logic                          valid;
    logic                          ready;
    logic [lecm_pkg::NODE_W-1:0]   out_node;
    logic [lecm_pkg::ENERGY_W-1:0] energy_sum;
    logic [lecm_pkg::SUM_W-1:0]    comfort_error_sum;
    logic [lecm_pkg::SUM_W-1:0]    flicker_sum;

    modport source (output valid, out_node, energy_sum, comfort_error_sum, flicker_sum,
                    input ready);
    modport sink (input valid, out_node, energy_sum, comfort_error_sum, flicker_sum,
                  output ready);
endinterface

FILE: src/lighting_energy_comfort_metrics.sv
// Top level of the per-node lighting energy, comfort and flicker metrics block.
// Depends on lecm_pkg, lecm_in_if, lecm_out_if, lecm_ctrl and lecm_dp.
//
//  channel   dir  handshake        contents
//  i_in      in   valid/ready      op, node, pwm_value, illuminance, reference, timestamp_us
//  o_out     out  valid/ready      out_node, energy_sum, comfort_error_sum, flicker_sum
//  i_cfg     in   i_cfg_we only    restart_time_us
//
// One item at a time: an accepted item passes the interval, multiply and, when a slope flip
// needs the flicker quotient, divide steps before writeback to the result register, and the
// next item is taken after that writeback (restoring divider, one quotient bit per cycle).
// Reset is synchronous, active low, and clears all per-node sums and history at once.
// The result sits in an output register; a new item is taken while it waits, and the
// writeback of that item holds until the output register is free.
`timescale 1ns / 1ps

module lighting_energy_comfort_metrics (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lecm_in_if.sink                   i_in,
    lecm_out_if.source                o_out,
    input  logic                      i_cfg_we,
    input  logic [lecm_pkg::TS_W-1:0] i_cfg_wdata
);
    lecm_pkg::t_in_item   w_item;
    lecm_pkg::t_out_item  w_out_item;
    lecm_pkg::t_dp_cmd    w_cmd;
    lecm_pkg::t_dp_status w_status;
    logic                 w_in_ready;
    logic                 w_out_valid;

    assign w_item.op           = i_in.op;
    assign w_item.node         = i_in.node;
    assign w_item.pwm_value    = i_in.pwm_value;
    assign w_item.illuminance  = i_in.illuminance;
    assign w_item.reference    = i_in.reference;
    assign w_item.timestamp_us = i_in.timestamp_us;
    assign i_in.ready          = w_in_ready;

    lecm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lecm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (w_out_item)
    );

    assign o_out.valid             = w_out_valid;
    assign o_out.out_node          = w_out_item.out_node;
    assign o_out.energy_sum        = w_out_item.energy_sum;
    assign o_out.comfort_error_sum = w_out_item.comfort_error_sum;
    assign o_out.flicker_sum       = w_out_item.flicker_sum;

endmodule

FILE: src/lecm_div.sv
// Restoring divider, one quotient bit per cycle, for the flicker term.
// Depends on lecm_pkg and the assertion header.
`timescale 1ns / 1ps
`include "lighting_energy_comfort_metrics_assert.svh"

module lecm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lecm_pkg::NUM_W-1:0] i_dividend,
    input  logic [lecm_pkg::TS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [lecm_pkg::NUM_W-1:0] o_quotient
);
    localparam int STEP_W = $clog2(lecm_pkg::NUM_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_cnt;
    logic [lecm_pkg::NUM_W-1:0] r_quo;
    logic [lecm_pkg::TS_W-1:0]  r_rem;
    logic [lecm_pkg::TS_W-1:0]  r_div;

    logic [lecm_pkg::TS_W:0]    w_shift;
    logic [lecm_pkg::TS_W:0]    w_trial;
    logic                       w_bit;

    assign w_shift = {r_rem, r_quo[lecm_pkg::NUM_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};
    assign w_bit   = !w_trial[lecm_pkg::TS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(lecm_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lecm_pkg::NUM_W-2:0], w_bit};
            r_rem <= w_bit ? w_trial[lecm_pkg::TS_W-1:0] : w_shift[lecm_pkg::TS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `LECM_ASSERT_NEXT(a_start_runs, i_start, r_busy && r_cnt == '0, "divider did not start")

endmodule

FILE: src/lecm_dp.sv
// Datapath: per-node state, interval and slope logic, multipliers, sums, result register.
// Depends on lecm_pkg, lecm_div and the assertion header.
`timescale 1ns / 1ps
`include "lighting_energy_comfort_metrics_assert.svh"

module lecm_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lecm_pkg::TS_W-1:0] i_cfg_wdata,
    input  lecm_pkg::t_in_item        i_item,
    input  lecm_pkg::t_dp_cmd         i_cmd,
    output lecm_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lecm_pkg::t_out_item       o_out_item
);
    localparam int N = lecm_pkg::NODE_COUNT;

    function automatic logic [lecm_pkg::ENERGY_W-1:0] add_sat64(
        input logic [lecm_pkg::ENERGY_W-1:0] a,
        input logic [lecm_pkg::ENERGY_W-1:0] b
    );
        logic [lecm_pkg::ENERGY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[lecm_pkg::ENERGY_W] ? '1 : s[lecm_pkg::ENERGY_W-1:0];
    endfunction

    function automatic logic [lecm_pkg::SUM_W-1:0] add_sat48(
        input logic [lecm_pkg::SUM_W-1:0] a,
        input logic [lecm_pkg::SUM_W-1:0] b
    );
        logic [lecm_pkg::SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[lecm_pkg::SUM_W] ? '1 : s[lecm_pkg::SUM_W-1:0];
    endfunction

    logic [lecm_pkg::TS_W-1:0]     r_restart;
    lecm_pkg::t_in_item            r_item;

    logic [lecm_pkg::ENERGY_W-1:0] r_energy    [N];
    logic [lecm_pkg::SUM_W-1:0]    r_comfort   [N];
    logic [lecm_pkg::SUM_W-1:0]    r_flicker   [N];
    logic [lecm_pkg::TS_W-1:0]     r_last_duty [N];
    logic                          r_duty_seen [N];
    logic [lecm_pkg::ILLUM_W-1:0]  r_prev1     [N];
    logic [lecm_pkg::ILLUM_W-1:0]  r_prev2     [N];
    logic [lecm_pkg::TS_W-1:0]     r_last_illum[N];
    logic [lecm_pkg::CNT_W-1:0]    r_illum_cnt [N];

    logic [lecm_pkg::TS_W-1:0]     r_dt;
    logic [lecm_pkg::ABS_W-1:0]    r_abs_sum;
    logic                          r_need_div;
    logic                          r_do_energy;
    logic [lecm_pkg::PROD_W-1:0]   r_prod;

    logic                          r_out_valid;
    lecm_pkg::t_out_item           r_out;

    logic [lecm_pkg::NODE_IDX_W-1:0] w_idx;
    logic                          w_node_ok;
    logic [lecm_pkg::TS_W-1:0]     w_base;
    logic [lecm_pkg::TS_W:0]       w_diff;
    logic [lecm_pkg::TS_W-1:0]     w_dt;
    logic [lecm_pkg::ABS_W-1:0]    w_d0;
    logic [lecm_pkg::ABS_W-1:0]    w_d1;
    logic [lecm_pkg::ILLUM_W-1:0]  w_a0;
    logic [lecm_pkg::ILLUM_W-1:0]  w_a1;
    logic                          w_flip;
    logic                          w_history;
    logic [lecm_pkg::NUM_W-1:0]    w_num;
    logic                          w_div_done;
    logic [lecm_pkg::NUM_W-1:0]    w_quo;
    logic                          w_short;
    logic [lecm_pkg::ILLUM_W-1:0]  w_short_amt;
    logic [lecm_pkg::ENERGY_W-1:0] w_energy_new;
    logic [lecm_pkg::SUM_W-1:0]    w_comfort_new;
    logic [lecm_pkg::SUM_W-1:0]    w_flicker_new;
    logic                          w_is_illum;

    assign w_idx      = r_item.node[lecm_pkg::NODE_IDX_W-1:0];
    assign w_node_ok  = (int'(r_item.node) < N);
    assign w_is_illum = (r_item.op == lecm_pkg::OP_ILLUM);

    // elapsed time against the per-op base, zero when not moving forward
    always_comb begin
        if (w_is_illum) begin
            w_base = r_last_illum[w_idx];
        end else if (r_duty_seen[w_idx]) begin
            w_base = r_last_duty[w_idx];
        end else begin
            w_base = r_restart;
        end
    end

    assign w_diff = {1'b0, r_item.timestamp_us} - {1'b0, w_base};
    assign w_dt   = w_diff[lecm_pkg::TS_W] ? '0 : w_diff[lecm_pkg::TS_W-1:0];

    assign w_d0 = {1'b0, r_item.illuminance} - {1'b0, r_prev1[w_idx]};
    assign w_d1 = {1'b0, r_prev1[w_idx]} - {1'b0, r_prev2[w_idx]};
    assign w_a0 = w_d0[lecm_pkg::ABS_W-1] ? lecm_pkg::ILLUM_W'(~w_d0 + 1'b1)
                                          : w_d0[lecm_pkg::ILLUM_W-1:0];
    assign w_a1 = w_d1[lecm_pkg::ABS_W-1] ? lecm_pkg::ILLUM_W'(~w_d1 + 1'b1)
                                          : w_d1[lecm_pkg::ILLUM_W-1:0];
    assign w_flip = (!w_d0[lecm_pkg::ABS_W-1] && w_d0 != '0 && w_d1[lecm_pkg::ABS_W-1])
                 || (w_d0[lecm_pkg::ABS_W-1] && !w_d1[lecm_pkg::ABS_W-1] && w_d1 != '0);
    assign w_history = (int'(r_illum_cnt[w_idx]) >= lecm_pkg::HISTORY_NEEDED);

    assign w_num = r_abs_sum * lecm_pkg::FLICKER_SCALE;

    lecm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_short     = r_item.reference > r_item.illuminance;
    assign w_short_amt = r_item.reference - r_item.illuminance;

    assign w_energy_new = r_do_energy
        ? add_sat64(r_energy[w_idx], lecm_pkg::ENERGY_W'(r_prod)) : r_energy[w_idx];
    assign w_comfort_new = (w_is_illum && w_short)
        ? add_sat48(r_comfort[w_idx], lecm_pkg::SUM_W'(w_short_amt)) : r_comfort[w_idx];
    assign w_flicker_new = r_need_div
        ? add_sat48(r_flicker[w_idx], lecm_pkg::SUM_W'(w_quo)) : r_flicker[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= '0;
        end else if (i_cfg_we) begin
            r_restart <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.calc) begin
            r_dt        <= w_dt;
            r_abs_sum   <= {1'b0, w_a0} + {1'b0, w_a1};
            r_need_div  <= w_node_ok && w_is_illum && w_history && w_flip && (w_dt != '0);
            r_do_energy <= w_node_ok && !w_is_illum && (w_dt != '0);
        end
        if (i_cmd.mul) begin
            r_prod <= r_item.pwm_value * r_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_energy[i]     <= '0;
                r_comfort[i]    <= '0;
                r_flicker[i]    <= '0;
                r_last_duty[i]  <= '0;
                r_duty_seen[i]  <= 1'b0;
                r_prev1[i]      <= '0;
                r_prev2[i]      <= '0;
                r_last_illum[i] <= '0;
                r_illum_cnt[i]  <= '0;
            end
        end else if (i_cmd.wb && w_node_ok) begin
            r_energy[w_idx]  <= w_energy_new;
            r_comfort[w_idx] <= w_comfort_new;
            r_flicker[w_idx] <= w_flicker_new;
            if (w_is_illum) begin
                r_prev2[w_idx]      <= r_prev1[w_idx];
                r_prev1[w_idx]      <= r_item.illuminance;
                r_last_illum[w_idx] <= r_item.timestamp_us;
                if (!w_history) begin
                    r_illum_cnt[w_idx] <= r_illum_cnt[w_idx] + 1'b1;
                end
            end else begin
                r_last_duty[w_idx] <= r_item.timestamp_us;
                r_duty_seen[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wb) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out.out_node <= r_item.node;
            if (w_node_ok) begin
                r_out.energy_sum        <= w_energy_new;
                r_out.comfort_error_sum <= w_comfort_new;
                r_out.flicker_sum       <= w_flicker_new;
            end else begin
                r_out.energy_sum        <= '0;
                r_out.comfort_error_sum <= '0;
                r_out.flicker_sum       <= '0;
            end
        end
    end

    assign o_status.need_div = r_need_div;
    assign o_status.div_done = w_div_done;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    `LECM_ASSERT_NEXT(a_wb_loads_out, i_cmd.wb, r_out_valid, "result not presented after writeback")

endmodule

FILE: src/lecm_ctrl.sv
// Controller FSM: sequences load, interval, multiply, divide and writeback per item.
// Depends on lecm_pkg and the assertion header.
`timescale 1ns / 1ps
`include "lighting_energy_comfort_metrics_assert.svh"

module lecm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lecm_pkg::t_dp_status i_status,
    output lecm_pkg::t_dp_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CALC;
            end
            S_CALC: n_state = S_MUL;
            S_MUL: begin
                n_state = i_status.need_div ? S_DIV : S_WB;
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_WB;
            end
            S_WB: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.calc      = (r_state == S_CALC);
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.div_start = (r_state == S_MUL) && i_status.need_div;
    assign o_cmd.wb        = (r_state == S_WB) && !i_status.out_busy;

    `LECM_ASSERT_IMPL(a_done_in_div, i_status.div_done, r_state == S_DIV, "divider done outside wait")
    `LECM_ASSERT_NEXT(a_wb_to_idle, o_cmd.wb, r_state == S_IDLE, "writeback did not return to idle")

endmodule
